@@ src/ppst_pkg.sv @@
// Shared types, constants and the arctangent table for the pure pursuit steering block.
package ppst_pkg;

   localparam int COORD_WIDTH_DEF   = 24;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int DIST_WIDTH  = 23;
   localparam int GAIN_WIDTH  = 8;
   localparam int SPEED_WIDTH = 9;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // CORDIC gain 0.60725 in Q30 and 2*pi in Q20.
   localparam logic signed [32:0] K_Q30      = 33'sd652032874;
   localparam logic signed [23:0] TWO_PI_Q20 = 24'sd6588397;

   localparam logic [DIST_WIDTH-1:0] LOOKAHEAD_RST = 23'd2560;
   localparam logic [DIST_WIDTH-1:0] WHEELBASE_RST = 23'd2560;
   localparam logic [DIST_WIDTH-1:0] REACH_RST     = 23'd1280;
   localparam logic [GAIN_WIDTH-1:0] GAIN_RST      = 8'd50;
   localparam logic [GAIN_WIDTH-1:0] BASE_RST      = 8'd100;

   // atan(2^-i) as 32-bit binary angles.
   localparam logic [31:0] ATAN_TAB [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef enum logic [2:0] {
      REG_LOOKAHEAD = 3'd0,
      REG_WHEELBASE = 3'd1,
      REG_REACH     = 3'd2,
      REG_GAIN      = 3'd3,
      REG_BASE      = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] lookahead_distance;
      logic [DIST_WIDTH-1:0] wheelbase;
      logic [DIST_WIDTH-1:0] reach_radius;
      logic [GAIN_WIDTH-1:0] steering_gain;
      logic [GAIN_WIDTH-1:0] base_speed;
   } cfg_type;

endpackage

@@ src/ppst_csr.sv @@
// Configuration register file with an APB-style access port.
module ppst_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ppst_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ppst_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ppst_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output ppst_pkg::cfg_type                    cfg
);
   import ppst_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_LOOKAHEAD: cfg_in.lookahead_distance = csr_pwdata[DIST_WIDTH-1:0];
            REG_WHEELBASE: cfg_in.wheelbase          = csr_pwdata[DIST_WIDTH-1:0];
            REG_REACH:     cfg_in.reach_radius       = csr_pwdata[DIST_WIDTH-1:0];
            REG_GAIN:      cfg_in.steering_gain      = csr_pwdata[GAIN_WIDTH-1:0];
            REG_BASE:      cfg_in.base_speed         = csr_pwdata[GAIN_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_LOOKAHEAD: csr_prdata = {{(CSR_DATA_W-DIST_WIDTH){1'b0}}, cfg_ff.lookahead_distance};
         REG_WHEELBASE: csr_prdata = {{(CSR_DATA_W-DIST_WIDTH){1'b0}}, cfg_ff.wheelbase};
         REG_REACH:     csr_prdata = {{(CSR_DATA_W-DIST_WIDTH){1'b0}}, cfg_ff.reach_radius};
         REG_GAIN:      csr_prdata = {{(CSR_DATA_W-GAIN_WIDTH){1'b0}}, cfg_ff.steering_gain};
         REG_BASE:      csr_prdata = {{(CSR_DATA_W-GAIN_WIDTH){1'b0}}, cfg_ff.base_speed};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lookahead_distance <= LOOKAHEAD_RST;
         cfg_ff.wheelbase          <= WHEELBASE_RST;
         cfg_ff.reach_radius       <= REACH_RST;
         cfg_ff.steering_gain      <= GAIN_RST;
         cfg_ff.base_speed         <= BASE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/ppst_vec_cordic.sv @@
// Pipelined CORDIC in vectoring mode: one register stage per iteration, angle out.
module ppst_vec_cordic #(
   parameter int XW      = 27,
   parameter int STAGES  = ppst_pkg::CORDIC_STAGES_DEF,
   parameter int SIDE_W  = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [XW-1:0]     in_x,
   input  logic signed [XW-1:0]     in_y,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [31:0]              out_z,
   output logic [SIDE_W-1:0]        out_side
);
   import ppst_pkg::*;

   logic                 v_st    [0:STAGES];
   logic signed [XW-1:0] x_st    [0:STAGES];
   logic signed [XW-1:0] y_st    [0:STAGES];
   logic [31:0]          z_st    [0:STAGES];
   logic [SIDE_W-1:0]    side_st [0:STAGES];

   logic                 v0_ff;
   logic signed [XW-1:0] x0_ff, y0_ff;
   logic [31:0]          z0_ff;
   logic [SIDE_W-1:0]    side0_ff;

   // A vector in the left half plane is first turned by a half turn.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         side0_ff <= in_side;
         if (in_x < 0) begin
            x0_ff <= -in_x;
            y0_ff <= -in_y;
            z0_ff <= 32'h8000_0000;
         end else begin
            x0_ff <= in_x;
            y0_ff <= in_y;
            z0_ff <= '0;
         end
      end
   end

   assign v_st[0]    = v0_ff;
   assign x_st[0]    = x0_ff;
   assign y_st[0]    = y0_ff;
   assign z_st[0]    = z0_ff;
   assign side_st[0] = side0_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic                 v_ff;
      logic signed [XW-1:0] x_ff, y_ff, x_in, y_in;
      logic [31:0]          z_ff, z_in;
      logic [SIDE_W-1:0]    side_ff;

      always_comb begin
         if (y_st[i] > 0) begin
            x_in = x_st[i] + (y_st[i] >>> i);
            y_in = y_st[i] - (x_st[i] >>> i);
            z_in = z_st[i] + ATAN_TAB[i];
         end else begin
            x_in = x_st[i] - (y_st[i] >>> i);
            y_in = y_st[i] + (x_st[i] >>> i);
            z_in = z_st[i] - ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_st[i];
         end
         if (en) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            side_ff <= side_st[i];
         end
      end

      assign v_st[i+1]    = v_ff;
      assign x_st[i+1]    = x_ff;
      assign y_st[i+1]    = y_ff;
      assign z_st[i+1]    = z_ff;
      assign side_st[i+1] = side_ff;
   end

   assign out_valid = v_st[STAGES];
   assign out_z     = z_st[STAGES];
   assign out_side  = side_st[STAGES];

endmodule

@@ src/ppst_rot_cordic.sv @@
// Pipelined CORDIC in rotation mode giving the sine of a binary angle in Q30.
module ppst_rot_cordic #(
   parameter int STAGES = ppst_pkg::CORDIC_STAGES_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [31:0]           in_angle,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic signed [32:0]    out_sin,
   output logic                  out_neg,
   output logic [SIDE_W-1:0]     out_side
);
   import ppst_pkg::*;

   localparam logic signed [32:0] QUARTER = 33'sh0_4000_0000;
   localparam logic signed [32:0] HALF    = 33'sh0_8000_0000;

   logic               v_st    [0:STAGES];
   logic signed [32:0] x_st    [0:STAGES];
   logic signed [32:0] y_st    [0:STAGES];
   logic signed [32:0] a_st    [0:STAGES];
   logic               neg_st  [0:STAGES];
   logic [SIDE_W-1:0]  side_st [0:STAGES];

   logic               v0_ff, neg0_ff, neg0_in;
   logic signed [32:0] a0_ff, a0_in, a_ext;
   logic [SIDE_W-1:0]  side0_ff;

   // Fold the angle into plus or minus a quarter turn; the sine then flips sign.
   always_comb begin
      a_ext   = {in_angle[31], in_angle};
      a0_in   = a_ext;
      neg0_in = 1'b0;
      if (a_ext > QUARTER) begin
         a0_in   = a_ext - HALF;
         neg0_in = 1'b1;
      end else if (a_ext < -QUARTER) begin
         a0_in   = a_ext + HALF;
         neg0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         a0_ff    <= a0_in;
         neg0_ff  <= neg0_in;
         side0_ff <= in_side;
      end
   end

   assign v_st[0]    = v0_ff;
   assign x_st[0]    = K_Q30;
   assign y_st[0]    = '0;
   assign a_st[0]    = a0_ff;
   assign neg_st[0]  = neg0_ff;
   assign side_st[0] = side0_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic               v_ff, neg_ff;
      logic signed [32:0] x_ff, y_ff, a_ff, x_in, y_in, a_in;
      logic [SIDE_W-1:0]  side_ff;

      always_comb begin
         if (a_st[i] >= 0) begin
            x_in = x_st[i] - (y_st[i] >>> i);
            y_in = y_st[i] + (x_st[i] >>> i);
            a_in = a_st[i] - $signed({1'b0, ATAN_TAB[i]});
         end else begin
            x_in = x_st[i] + (y_st[i] >>> i);
            y_in = y_st[i] - (x_st[i] >>> i);
            a_in = a_st[i] + $signed({1'b0, ATAN_TAB[i]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_st[i];
         end
         if (en) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            a_ff    <= a_in;
            neg_ff  <= neg_st[i];
            side_ff <= side_st[i];
         end
      end

      assign v_st[i+1]    = v_ff;
      assign x_st[i+1]    = x_ff;
      assign y_st[i+1]    = y_ff;
      assign a_st[i+1]    = a_ff;
      assign neg_st[i+1]  = neg_ff;
      assign side_st[i+1] = side_ff;
   end

   assign out_valid = v_st[STAGES];
   assign out_sin   = y_st[STAGES];
   assign out_neg   = neg_st[STAGES];
   assign out_side  = side_st[STAGES];

endmodule

@@ src/pure_pursuit_steering.sv @@
// Top level of the pure pursuit steering pipeline.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  robot pose and target position
//   rsp       out        rsp_valid/rsp_stall  wheel speeds, lookahead and reached flags
//   csr       in/out     APB psel/penable     five configuration registers
//
// One request enters per cycle while rsp_stall does not hold the pipeline; the path runs
// through the three CORDIC pipelines for bearing, sine and steering angle.
// Reset clears every valid bit and loads the register reset values.
// When a finished request waits at the output under rsp_stall, the whole pipeline holds;
// the output register lets a new request in during the cycle the waiting one leaves.
module pure_pursuit_steering #(
   parameter int COORD_WIDTH   = ppst_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ppst_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = ppst_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_robot_x,
   input  logic signed [COORD_WIDTH-1:0]         req_robot_y,
   input  logic [ANGLE_WIDTH-1:0]                req_robot_heading,
   input  logic signed [COORD_WIDTH-1:0]         req_target_x,
   input  logic signed [COORD_WIDTH-1:0]         req_target_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ppst_pkg::SPEED_WIDTH-1:0] rsp_left_speed,
   output logic signed [ppst_pkg::SPEED_WIDTH-1:0] rsp_right_speed,
   output logic                                  rsp_has_lookahead,
   output logic                                  rsp_target_reached,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ppst_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ppst_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ppst_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import ppst_pkg::*;

   // Coordinate difference width, bearing CORDIC width, numerator width, steering CORDIC width, square width.
   localparam int DW  = COORD_WIDTH + 1;
   localparam int XW1 = COORD_WIDTH + 3;
   localparam int NW  = 59;
   localparam int XW2 = NW + 2;
   localparam int SQW = 48;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0] hd;
      logic                   la;
      logic                   reached;
   } head_side_type;

   typedef struct packed {
      logic la;
      logic reached;
   } flag_side_type;

   cfg_type cfg;
   logic    en;

   // The pipeline moves whenever the output register is empty or being taken.
   assign en        = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~en;

   ppst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stage 1: vector from robot to target.
   logic                    p1_valid_ff;
   logic signed [DW-1:0]    p1_dx_ff, p1_dy_ff;
   logic [ANGLE_WIDTH-1:0]  p1_hd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= req_valid;
      end
      if (en) begin
         p1_dx_ff <= DW'(req_target_x) - DW'(req_robot_x);
         p1_dy_ff <= DW'(req_target_y) - DW'(req_robot_y);
         p1_hd_ff <= req_robot_heading;
      end
   end

   // Stage 2: magnitudes, far test and the squares of distances and radii.
   logic [DW-1:0]            adx, ady;
   logic                     p2_valid_ff, p2_far_ff, far_in;
   logic signed [DW-1:0]     p2_dx_ff, p2_dy_ff;
   logic [ANGLE_WIDTH-1:0]   p2_hd_ff;
   logic [SQW-1:0]           p2_sqx_ff, p2_sqy_ff;
   logic [2*DIST_WIDTH-1:0]  p2_ll_ff, p2_rr_ff;
   logic [23:0]              adx24, ady24;

   assign adx    = p1_dx_ff[DW-1] ? DW'(-p1_dx_ff) : p1_dx_ff;
   assign ady    = p1_dy_ff[DW-1] ? DW'(-p1_dy_ff) : p1_dy_ff;
   assign far_in = ({{(34-DW){1'b0}}, adx} >= 34'd16777216)
                 || ({{(34-DW){1'b0}}, ady} >= 34'd16777216);
   assign adx24  = 24'({{(34-DW){1'b0}}, adx});
   assign ady24  = 24'({{(34-DW){1'b0}}, ady});

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         p2_far_ff <= far_in;
         p2_dx_ff  <= p1_dx_ff;
         p2_dy_ff  <= p1_dy_ff;
         p2_hd_ff  <= p1_hd_ff;
         p2_sqx_ff <= adx24 * adx24;
         p2_sqy_ff <= ady24 * ady24;
         p2_ll_ff  <= cfg.lookahead_distance * cfg.lookahead_distance;
         p2_rr_ff  <= cfg.reach_radius * cfg.reach_radius;
      end
   end

   // Stage 3: lookahead and reached decisions from the squared distance.
   logic [SQW:0]            d2;
   logic                    p3_valid_ff, p3_la_ff, p3_reached_ff, la_in, reached_in;
   logic signed [DW-1:0]    p3_dx_ff, p3_dy_ff;
   logic [ANGLE_WIDTH-1:0]  p3_hd_ff;

   assign d2         = {1'b0, p2_sqx_ff} + {1'b0, p2_sqy_ff};
   assign la_in      = (cfg.lookahead_distance != '0)
                     && (p2_far_ff || ({{(SQW+1-2*DIST_WIDTH){1'b0}}, p2_ll_ff} <= d2));
   assign reached_in = ~p2_far_ff
                     && (d2 < {{(SQW+1-2*DIST_WIDTH){1'b0}}, p2_rr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (en) begin
         p3_la_ff      <= la_in;
         p3_reached_ff <= reached_in;
         p3_dx_ff      <= p2_dx_ff;
         p3_dy_ff      <= p2_dy_ff;
         p3_hd_ff      <= p2_hd_ff;
      end
   end

   // Bearing to the target.
   head_side_type b_side_in, b_side_out;
   logic          b_valid;
   logic [31:0]   bearing;

   assign b_side_in = '{hd: p3_hd_ff, la: p3_la_ff, reached: p3_reached_ff};

   ppst_vec_cordic #(
      .XW     (XW1),
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(head_side_type))
   ) u_bearing (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p3_valid_ff),
      .in_x      ({{2{p3_dx_ff[DW-1]}}, p3_dx_ff}),
      .in_y      ({{2{p3_dy_ff[DW-1]}}, p3_dy_ff}),
      .in_side   (b_side_in),
      .out_valid (b_valid),
      .out_z     (bearing),
      .out_side  (b_side_out)
   );

   // Sine of alpha, the bearing less the heading in 32-bit binary angle.
   logic [31:0]        alpha, head32;
   flag_side_type      s_side_in, s_side_out;
   logic               s_valid, s_neg;
   logic signed [32:0] s_raw;

   assign head32    = {b_side_out.hd, {(32-ANGLE_WIDTH){1'b0}}};
   assign alpha     = bearing - head32;
   assign s_side_in = '{la: b_side_out.la, reached: b_side_out.reached};

   ppst_rot_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(flag_side_type))
   ) u_sine (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid),
      .in_angle  (alpha),
      .in_side   (s_side_in),
      .out_valid (s_valid),
      .out_sin   (s_raw),
      .out_neg   (s_neg),
      .out_side  (s_side_out)
   );

   // Stage 4: apply the sign from the quadrant fold.
   logic               p4_valid_ff;
   logic signed [33:0] p4_sin_ff;
   flag_side_type      p4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (en) begin
         p4_valid_ff <= s_valid;
      end
      if (en) begin
         p4_sin_ff  <= s_neg ? -{s_raw[32], s_raw} : {s_raw[32], s_raw};
         p4_side_ff <= s_side_out;
      end
   end

   // Stage 5: numerator 2*W*sin(alpha) for the steering angle.
   logic               p5_valid_ff;
   logic signed [NW-1:0] p5_num_ff;
   logic signed [57:0] num_prod;
   flag_side_type      p5_side_ff;

   assign num_prod = p4_sin_ff * $signed({1'b0, cfg.wheelbase});

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (en) begin
         p5_valid_ff <= p4_valid_ff;
      end
      if (en) begin
         p5_num_ff  <= {num_prod, 1'b0};
         p5_side_ff <= p4_side_ff;
      end
   end

   // Steering angle: vectoring angle of (L * 2^30, 2*W*sin(alpha)).
   logic signed [XW2-1:0] den;
   logic                  t_valid;
   logic [31:0]           steer;
   flag_side_type         t_side_out;

   assign den = {{(XW2-DIST_WIDTH-30){1'b0}}, cfg.lookahead_distance, 30'd0};

   ppst_vec_cordic #(
      .XW     (XW2),
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(flag_side_type))
   ) u_steer (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p5_valid_ff),
      .in_x      (den),
      .in_y      ({{2{p5_num_ff[NW-1]}}, p5_num_ff}),
      .in_side   (p5_side_ff),
      .out_valid (t_valid),
      .out_z     (steer),
      .out_side  (t_side_out)
   );

   // Stage 6: gain times steering angle.
   logic               p6_valid_ff;
   logic signed [40:0] p6_t_ff;
   flag_side_type      p6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else if (en) begin
         p6_valid_ff <= t_valid;
      end
      if (en) begin
         p6_t_ff    <= $signed({1'b0, cfg.steering_gain}) * $signed(steer);
         p6_side_ff <= t_side_out;
      end
   end

   // Stage 7: scale to speed units in Q16; the floor comes from keeping the high bits.
   logic               p7_valid_ff;
   logic signed [28:0] p7_d16_ff;
   logic signed [64:0] dprod;
   flag_side_type      p7_side_ff;

   assign dprod = p6_t_ff * TWO_PI_Q20;

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_valid_ff <= 1'b0;
      end else if (en) begin
         p7_valid_ff <= p6_valid_ff;
      end
      if (en) begin
         p7_d16_ff  <= dprod[64:36];
         p7_side_ff <= p6_side_ff;
      end
   end

   // Output stage: differential, saturation and truncation toward zero.
   function automatic logic signed [SPEED_WIDTH-1:0] sat_trunc(input logic signed [30:0] v);
      logic signed [30:0] lim;
      logic [30:0]        mag;
      lim = 31'sd16711680;
      mag = '0;
      if (v > lim) begin
         sat_trunc = 9'sd255;
      end else if (v < -lim) begin
         sat_trunc = -9'sd255;
      end else if (v >= 0) begin
         sat_trunc = v[24:16];
      end else begin
         mag       = 31'(-v);
         sat_trunc = -$signed(mag[24:16]);
      end
   endfunction

   logic signed [30:0] base16, d16x, left_q16, right_q16;
   logic               go;
   logic               rsp_valid_ff, rsp_la_ff, rsp_reached_ff;
   logic signed [SPEED_WIDTH-1:0] rsp_left_ff, rsp_right_ff, left_in, right_in;

   assign base16    = {7'd0, cfg.base_speed, 16'd0};
   assign d16x      = {{2{p7_d16_ff[28]}}, p7_d16_ff};
   assign left_q16  = base16 - d16x;
   assign right_q16 = base16 + d16x;
   assign go        = p7_side_ff.la & ~p7_side_ff.reached;
   assign left_in   = go ? sat_trunc(left_q16) : '0;
   assign right_in  = go ? sat_trunc(right_q16) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p7_valid_ff;
      end
      if (en) begin
         rsp_left_ff    <= left_in;
         rsp_right_ff   <= right_in;
         rsp_la_ff      <= p7_side_ff.la;
         rsp_reached_ff <= p7_side_ff.reached;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_speed     = rsp_left_ff;
   assign rsp_right_speed    = rsp_right_ff;
   assign rsp_has_lookahead  = rsp_la_ff;
   assign rsp_target_reached = rsp_reached_ff;

`ifndef SYNTHESIS
   // A stopped robot gets zero on both wheels.
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_has_lookahead || rsp_target_reached)
      |-> (rsp_left_speed == '0) && (rsp_right_speed == '0))
      else $error("speeds not zero for a stopped robot");

   // Saturation never lets a command reach the most negative code.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed != -9'sd256) && (rsp_right_speed != -9'sd256))
      else $error("speed command outside the saturation range");

   // With zero base speed the differential is symmetric.
   a_symmetric: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cfg.base_speed == '0) |-> rsp_left_speed == -rsp_right_speed)
      else $error("left and right speeds not symmetric at zero base speed");

   // A held pipeline keeps its output result.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(rsp_left_speed) && $stable(rsp_right_speed) && rsp_valid)
      else $error("output changed while held");
`endif

endmodule

@@ tb/sv/pure_pursuit_steering_tb.sv @@
// Self-checking testbench for the pure pursuit steering block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ppst_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int AW = ANGLE_WIDTH_DEF;
   localparam int NST = CORDIC_STAGES_DEF;
   localparam int LATENCY = 3 * NST + 11;
   localparam longint LIMIT_SQ16 = 255 * 65536;

   typedef struct packed {
      logic signed [SPEED_WIDTH-1:0] left_speed;
      logic signed [SPEED_WIDTH-1:0] right_speed;
      logic                          has_lookahead;
      logic                          target_reached;
   } steer_result_type;

   // Holds the predicted steering results in request order and checks each response.
   class steer_scoreboard;
      steer_result_type pending[$];
      int mismatches;
      int failures;

      function void note_request(steer_result_type r);
         pending.push_back(r);
      endfunction

      function void check_response(steer_result_type got);
         steer_result_type want;
         if (pending.size() == 0) begin
            failures++;
            if (mismatches < 10)
               $display("unexpected response %p", got);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (want !== got) begin
            failures++;
            if (mismatches < 10)
               $display("mismatch: expected %p, got %p", want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_robot_x = '0, req_robot_y = '0;
   logic [AW-1:0] req_robot_heading = '0;
   logic signed [CW-1:0] req_target_x = '0, req_target_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SPEED_WIDTH-1:0] rsp_left_speed, rsp_right_speed;
   logic rsp_has_lookahead, rsp_target_reached;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   pure_pursuit_steering i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   steer_scoreboard board = new();

   // Mirror of the configuration registers as the predictor sees them.
   longint lookahead_q, wheelbase_q, reach_q, gain_q, base_q;

   int atan_q [0:23];
   initial for (int i = 0; i < 24; i++) atan_q[i] = ATAN_TAB[i];

   // Shift right rounding toward minus infinity; SystemVerilog >>> on signed does this.
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Vectoring CORDIC: angle of (x, y) as an unwrapped 32-bit binary angle.
   function automatic longint cordic_angle(longint x, longint y);
      longint z = 0;
      longint xs, ys;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 64'sd2147483648;
      end
      for (int i = 0; i < NST; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += atan_q[i];
         end else begin
            x -= ys; y += xs; z -= atan_q[i];
         end
      end
      return z;
   endfunction

   // Rotation CORDIC: sine of a 32-bit binary angle in Q30.
   function automatic longint cordic_sine(logic [31:0] ang);
      longint a = ang;
      longint x = K_Q30;
      longint y = 0;
      longint xs, ys;
      bit flip = 0;
      if (a >= 64'sd2147483648) a -= 64'sd4294967296;
      // Fold into plus or minus a quarter turn; the result then changes sign.
      if (a > 64'sd1073741824) begin
         a -= 64'sd2147483648; flip = 1;
      end else if (a < -64'sd1073741824) begin
         a += 64'sd2147483648; flip = 1;
      end
      for (int i = 0; i < NST; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (a >= 0) begin
            x -= ys; y += xs; a -= atan_q[i];
         end else begin
            x += ys; y -= xs; a += atan_q[i];
         end
      end
      return flip ? -y : y;
   endfunction

   function automatic longint clamp_speed(longint v);
      if (v > LIMIT_SQ16) v = LIMIT_SQ16;
      if (v < -LIMIT_SQ16) v = -LIMIT_SQ16;
      return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
   endfunction

   function automatic steer_result_type predict_steering(logic signed [CW-1:0] rx,
         logic signed [CW-1:0] ry, logic [AW-1:0] hd, logic signed [CW-1:0] tx,
         logic signed [CW-1:0] ty);
      steer_result_type r;
      longint dx, dy, adx, ady, d2, bearing, s, steer, d16, lsp, rsp;
      logic [31:0] alpha, head;
      bit far, la, hit;
      dx = longint'(tx) - longint'(rx);
      dy = longint'(ty) - longint'(ry);
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      far = adx >= (64'sd1 << 24) || ady >= (64'sd1 << 24);
      d2 = far ? 0 : adx * adx + ady * ady;
      la = lookahead_q != 0 && (far || lookahead_q * lookahead_q <= d2);
      hit = !far && d2 < reach_q * reach_q;
      lsp = 0;
      rsp = 0;
      if (la && !hit) begin
         bearing = cordic_angle(dx, dy);
         head = 32'(hd) << (32 - AW);
         alpha = 32'(bearing) - head;
         s = cordic_sine(alpha);
         steer = cordic_angle(lookahead_q * 64'sd1073741824, 2 * wheelbase_q * s);
         d16 = floor_shift(gain_q * steer * TWO_PI_Q20, 36);
         lsp = clamp_speed(base_q * 65536 - d16);
         rsp = clamp_speed(base_q * 65536 + d16);
      end
      r.left_speed = SPEED_WIDTH'(lsp);
      r.right_speed = SPEED_WIDTH'(rsp);
      r.has_lookahead = la;
      r.target_reached = hit;
      return r;
   endfunction

   // Response side: random stalls, and every accepted response goes to the scoreboard.
   int stall_left = 0;
   bit calm = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response({rsp_left_speed, rsp_right_speed,
                                  rsp_has_lookahead, rsp_target_reached});
         if (rsp_valid && !rsp_stall) stall_left = calm ? 0 : $urandom_range(0, 15);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(reg_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * int'(idx)); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_LOOKAHEAD: lookahead_q = value[DIST_WIDTH-1:0];
         REG_WHEELBASE: wheelbase_q = value[DIST_WIDTH-1:0];
         REG_REACH:     reach_q = value[DIST_WIDTH-1:0];
         REG_GAIN:      gain_q = value[GAIN_WIDTH-1:0];
         default:       base_q = value[GAIN_WIDTH-1:0];
      endcase
   endtask

   task automatic send_request(logic signed [CW-1:0] rx, logic signed [CW-1:0] ry,
         logic [AW-1:0] hd, logic signed [CW-1:0] tx, logic signed [CW-1:0] ty,
         bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_robot_x <= rx; req_robot_y <= ry; req_robot_heading <= hd;
      req_target_x <= tx; req_target_y <= ty;
      do @(posedge clock); while (req_stall);
      board.note_request(predict_steering(rx, ry, hd, tx, ty));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Random pose with a target at a controllable spread, offset so far targets show up too.
   task automatic random_request(int spread_bits, bit no_gap);
      logic signed [CW-1:0] rx, ry, tx, ty;
      rx = CW'($urandom); ry = CW'($urandom);
      tx = rx + CW'($signed($urandom) >>> (32 - spread_bits));
      ty = ry + CW'($signed($urandom) >>> (32 - spread_bits));
      send_request(rx, ry, AW'($urandom), tx, ty, no_gap);
   endtask

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   initial begin
      lookahead_q = LOOKAHEAD_RST; wheelbase_q = WHEELBASE_RST; reach_q = REACH_RST;
      gain_q = GAIN_RST; base_q = BASE_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, extremes, robot on target, far target, reach and lookahead boundaries.
      send_request(0, 0, 0, 0, 0, 0);
      send_request(0, 0, 0, 5000, 0, 0);
      send_request(0, 0, 16'h4000, 0, 5000, 0);
      send_request(0, 0, 16'hFFFF, -5000, 0, 0);
      send_request(0, 0, 16'h8000, 0, -5000, 0);
      send_request(0, 0, 0, 1279, 0, 0);
      send_request(0, 0, 0, 1280, 0, 0);
      send_request(0, 0, 0, 2559, 0, 0);
      send_request(0, 0, 0, 2560, 0, 0);
      send_request(CMIN, CMIN, 16'h1234, CMAX, CMAX, 0);
      send_request(CMAX, CMAX, 16'hEDCB, CMIN, CMIN, 0);
      send_request(CMAX, CMIN, 16'h5555, CMIN, CMAX, 0);
      send_request(-100, 200, 16'hAAAA, 4000, -3000, 0);
      wait_drained();

      // Zero wheelbase, zero lookahead, high gain and base speed for saturation.
      write_reg(REG_WHEELBASE, 0);
      write_reg(REG_GAIN, 255);
      send_request(0, 0, 16'h3000, 9000, 100, 0);
      wait_drained();
      write_reg(REG_LOOKAHEAD, 0);
      write_reg(REG_REACH, 0);
      send_request(0, 0, 0, 9000, 100, 0);
      send_request(5, 5, 0, 5, 5, 0);
      wait_drained();
      write_reg(REG_LOOKAHEAD, 23'h7FFFFF);
      write_reg(REG_WHEELBASE, 23'h7FFFFF);
      write_reg(REG_BASE, 255);
      send_request(0, 0, 16'h4000, 100000, 0, 0);
      send_request(0, 0, 16'hC000, 100000, 0, 0);
      send_request(CMIN, 0, 0, CMAX, 0, 0);
      wait_drained();

      // Random phases under several settings, small sizes for most.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_LOOKAHEAD, 2560); write_reg(REG_WHEELBASE, 2560);
               write_reg(REG_REACH, 1280); write_reg(REG_GAIN, 50); write_reg(REG_BASE, 100);
            end
            1: begin
               write_reg(REG_LOOKAHEAD, 1); write_reg(REG_REACH, 23'h7FFFFF);
               write_reg(REG_GAIN, 0); write_reg(REG_BASE, 0);
            end
            default: begin
               write_reg(REG_LOOKAHEAD, $urandom_range(1, 20000));
               write_reg(REG_WHEELBASE, $urandom_range(0, 40000));
               write_reg(REG_REACH, $urandom_range(0, 3000));
               write_reg(REG_GAIN, $urandom_range(0, 255));
               write_reg(REG_BASE, $urandom_range(0, 255));
            end
         endcase
         calm = (phase == 3);
         for (int n = 0; n < 155; n++) begin
            random_request((n % 7 == 0) ? 32 : $urandom_range(12, 18),
                           calm || (n % 40 < 10));
            // Hold the sender once until every expected response has arrived.
            if (phase == 2 && n == 70) begin
               req_valid <= 1'b0;
               while (board.pending.size() != 0) @(posedge clock);
            end
         end
         wait_drained();
      end
      calm = 0;

      if (board.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ filelist.f @@
src/ppst_pkg.sv
src/ppst_csr.sv
src/ppst_vec_cordic.sv
src/ppst_rot_cordic.sv
src/pure_pursuit_steering.sv
tb/sv/pure_pursuit_steering_tb.sv
